// ----- design/mhpq_pkg.sv -----
// ============================================================================
// mhpq_pkg
// Shared types, field widths, status codes and the key compare for the
// min-heap priority queue.
// ============================================================================
package mhpq_pkg;

  localparam int ID_W           = 31;
  localparam int TIME_W         = 32;
  localparam int COUNT_W        = 12;
  localparam int STATUS_W       = 2;
  localparam int CAPACITY_DFLT  = 2048;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] executed;
    logic [TIME_W-1:0] total;
  } entry_t;

  // Order by executed time, then by id; strict, so equal keys never move
  function automatic logic key_less(input entry_t a, input entry_t b);
    logic lt;
    lt = (a.executed < b.executed) ||
         ((a.executed == b.executed) && (a.id < b.id));
    return lt;
  endfunction

endpackage

// ----- design/mhpq_req_if.sv -----
// ============================================================================
// mhpq_req_if
// Request channel: one insert or remove-minimum request per handshake.
// ============================================================================
interface mhpq_req_if
  import mhpq_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ID_W-1:0]   item_id;
  logic [TIME_W-1:0] item_executed;
  logic [TIME_W-1:0] item_total;

  modport source (output valid, action, item_id, item_executed, item_total,
                  input ready);
  modport sink   (input valid, action, item_id, item_executed, item_total,
                  output ready);
endinterface

// ----- design/mhpq_rsp_if.sv -----
// ============================================================================
// mhpq_rsp_if
// Response channel: status, entry count and the current minimum entry.
// ============================================================================
interface mhpq_rsp_if
  import mhpq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic                top_valid;
  logic [ID_W-1:0]     top_id;
  logic [TIME_W-1:0]   top_executed;
  logic [TIME_W-1:0]   top_total;

  modport source (output valid, status, count, top_valid, top_id, top_executed,
                         top_total,
                  input ready);
  modport sink   (input valid, status, count, top_valid, top_id, top_executed,
                         top_total,
                  output ready);
endinterface

// ----- design/mhpq_mem.sv -----
// ============================================================================
// mhpq_mem
// Heap entry store: one write port and one read port with registered data.
// ============================================================================
module mhpq_mem
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DFLT,
  localparam int AW      = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [CAPACITY];

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read with registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/mhpq_ctrl.sv -----
// ============================================================================
// mhpq_ctrl
// Sift sequencer: walks the heap one level at a time through the shared key
// compare and the store's read and write ports, and holds the response register.
// ============================================================================
module mhpq_ctrl
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DFLT,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CNTW    = $clog2(CAPACITY + 1),
  localparam int IW      = AW + 2
) (
  input  logic          clk,
  input  logic          rst,
  mhpq_req_if.sink      req,
  mhpq_rsp_if.source    rsp,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output entry_t        mem_wr_data,
  output logic          mem_rd_en,
  output logic [AW-1:0] mem_rd_addr,
  input  entry_t        mem_rd_data
);

  localparam logic [CNTW-1:0] CAP_CNT = CNTW'(CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_LOAD,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_R,
    ST_FINISH
  } state_t;

  state_t          state;
  logic [CNTW-1:0] cnt;
  logic [AW-1:0]   pos;
  entry_t          cur;
  entry_t          best;
  logic            best_child;
  logic [AW-1:0]   best_idx;
  entry_t          top;
  status_t         status;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [COUNT_W-1:0]  rsp_count;
  logic                rsp_top_valid;
  entry_t              rsp_top;

  logic [AW-1:0] pos_parent;
  logic [IW-1:0] left_idx;
  logic [IW-1:0] right_idx;
  logic [IW-1:0] cnt_ext;
  logic          left_ok;
  logic          right_ok;
  logic          less_cur;
  logic          less_rd_cur;
  logic          less_rd_best;
  entry_t        item;

  // Index arithmetic for the current level
  assign pos_parent = (pos - AW'(1)) >> 1;
  assign left_idx   = {1'b0, pos, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign cnt_ext    = IW'(cnt);
  assign left_ok    = left_idx < cnt_ext;
  assign right_ok   = right_idx < cnt_ext;

  // Shared key compares against the entry just read
  assign less_cur     = key_less(cur, mem_rd_data);
  assign less_rd_cur  = key_less(mem_rd_data, cur);
  assign less_rd_best = key_less(mem_rd_data, best);

  assign item.id       = req.item_id;
  assign item.executed = req.item_executed;
  assign item.total    = req.item_total;

  assign req.ready = (state == ST_IDLE);

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.count        = rsp_count;
  assign rsp.top_valid    = rsp_top_valid;
  assign rsp.top_id       = rsp_top.id;
  assign rsp.top_executed = rsp_top.executed;
  assign rsp.top_total    = rsp_top.total;

  // Drive the store ports for the current step
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = pos;
    mem_wr_data = cur;
    mem_rd_en   = 1'b0;
    mem_rd_addr = pos;
    case (state)
      ST_UP_CHK: begin
        if (pos == '0) begin
          mem_wr_en = 1'b1;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = pos_parent;
        end
      end
      ST_UP_CMP: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = less_cur ? mem_rd_data : cur;
      end
      ST_DN_LAST: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt[AW-1:0];
      end
      ST_DN_CHK: begin
        if (!left_ok) begin
          mem_wr_en = 1'b1;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = left_idx[AW-1:0];
        end
      end
      ST_DN_L: begin
        if (right_ok) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = right_idx[AW-1:0];
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_data = less_rd_cur ? mem_rd_data : cur;
        end
      end
      ST_DN_R: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = less_rd_best ? mem_rd_data : best;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, shadow root and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response once taken; a finishing request refills it below
      if (rsp_valid && rsp.ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      // Mirror every root write
      if (mem_wr_en && (mem_wr_addr == '0)) begin
        top <= mem_wr_data;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            if (req.action == ACT_INSERT) begin
              if (cnt == CAP_CNT) begin
                status <= STATUS_FULL;
                state  <= ST_FINISH;
              end else begin
                status <= STATUS_DONE;
                cur    <= item;
                pos    <= cnt[AW-1:0];
                cnt    <= cnt + CNTW'(1);
                state  <= ST_UP_CHK;
              end
            end else begin
              if (cnt == '0) begin
                status <= STATUS_EMPTY;
                state  <= ST_FINISH;
              end else begin
                status <= STATUS_DONE;
                cnt    <= cnt - CNTW'(1);
                pos    <= '0;
                state  <= ST_DN_LAST;
              end
            end
          end
        end
        ST_UP_CHK: begin
          state <= (pos == '0) ? ST_FINISH : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (less_cur) begin
            pos   <= pos_parent;
            state <= ST_UP_CHK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DN_LAST: begin
          state <= ST_DN_LOAD;
        end
        ST_DN_LOAD: begin
          cur   <= mem_rd_data;
          state <= (cnt == '0) ? ST_FINISH : ST_DN_CHK;
        end
        ST_DN_CHK: begin
          state <= left_ok ? ST_DN_L : ST_FINISH;
        end
        ST_DN_L: begin
          if (right_ok) begin
            best       <= less_rd_cur ? mem_rd_data : cur;
            best_child <= less_rd_cur;
            best_idx   <= left_idx[AW-1:0];
            state      <= ST_DN_R;
          end else if (less_rd_cur) begin
            pos   <= left_idx[AW-1:0];
            state <= ST_DN_CHK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DN_R: begin
          if (less_rd_best) begin
            pos   <= right_idx[AW-1:0];
            state <= ST_DN_CHK;
          end else if (best_child) begin
            pos   <= best_idx;
            state <= ST_DN_CHK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the response slot is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid     <= 1'b1;
            rsp_status    <= status;
            rsp_count     <= COUNT_W'(cnt);
            rsp_top_valid <= (cnt != '0);
            rsp_top       <= (cnt != '0) ? top : '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/min_heap_priority_queue.sv -----
// ============================================================================
// min_heap_priority_queue
// Binary min-heap of job entries keyed by executed time, then id.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+------------------------------------------
//   req     | in  | valid/ready  | action, item_id, item_executed, item_total
//   rsp     | out | valid/ready  | status, count, top_valid, top_id,
//           |     |              | top_executed, top_total
//
// Insert: the entry climbs one level per step from the last slot toward the
// root until it is not less than its parent. Remove: the last entry moves to
// the root and sifts down one level per step, read against each child in turn.
// A refused request (full or empty) goes straight to the response. The pace
// is set by the one read port of the entry store and the one key compare per
// step.
// Reset clears the entry count and the response slot; the store needs none.
// A stalled response holds in its register; a finished request then waits
// before the next request is taken.
// ============================================================================
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DFLT,
  localparam int AW      = $clog2(CAPACITY)
) (
  input  logic       clk,
  input  logic       rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;

  // Sequencer
  mhpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // Entry store
  mhpq_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ----- design/mhpq_checker.sv -----
// ============================================================================
// mhpq_checker
// Port-level checks on the heap queue's requests and responses.
// ============================================================================
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [COUNT_W-1:0]  rsp_count,
  input logic                rsp_top_valid,
  input logic [ID_W-1:0]     rsp_top_id,
  input logic [TIME_W-1:0]   rsp_top_executed,
  input logic [TIME_W-1:0]   rsp_top_total
);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_count) && $stable(rsp_top_id) && $stable(rsp_top_executed))
    else $error("stalled response changed");

  // One request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // A nonzero count always comes with a top entry
  a_count_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_count != '0) |-> rsp_top_valid)
    else $error("count nonzero without top entry");

  // An empty heap reports zero count and zero top fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_top_valid |-> (rsp_count == '0) && (rsp_top_id == '0) &&
      (rsp_top_executed == '0) && (rsp_top_total == '0))
    else $error("empty heap with nonzero fields");

  // A refused remove leaves the heap empty
  a_refuse_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_EMPTY) |-> !rsp_top_valid)
    else $error("remove refused on a nonempty heap");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_count        (rsp.count),
  .rsp_top_valid    (rsp.top_valid),
  .rsp_top_id       (rsp.top_id),
  .rsp_top_executed (rsp.top_executed),
  .rsp_top_total    (rsp.top_total)
);
